### rtl/lsps_pkg.sv
// ----------------------------------------------------------------------------
// lsps_pkg: shared types, widths and helpers for the line sensor PID steering
// Fixed-point widths, register indexes, direction codes, sequencer states,
// the multiplier operand bundle and small arithmetic helpers.
// ----------------------------------------------------------------------------
package lsps_pkg;

	localparam int SENSOR_COUNT = 7;

	// error: sum of sensor weights, wide enough for up to 15 sensors
	localparam int ERR_W      = 8;
	localparam int LAST_ERR_W = 4;
	localparam int ACC_W      = 16;
	localparam int SUM_W      = 22;
	localparam int VOLT_W     = 16;

	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 15;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int RND_W   = PROD_W - 8;

	localparam int DUTY_W = 8;
	localparam int DIR_W  = 2;

	localparam int PROP_W   = 12;
	localparam int INTEG_W  = 8;
	localparam int DERIV_W  = 12;
	localparam int NORM_W   = 12;
	localparam int SUPPLY_W = 6;
	localparam int DGAIN_W  = 14;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_VOLTS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_GAIN    = 3'd5;

	localparam logic [PROP_W-1:0]   PROP_GAIN_RST    = 12'd384;
	localparam logic [INTEG_W-1:0]  INTEG_GAIN_RST   = 8'd192;
	localparam logic [DERIV_W-1:0]  DERIV_GAIN_RST   = 12'd154;
	localparam logic [NORM_W-1:0]   NORM_GAIN_RST    = 12'd1104;
	localparam logic [SUPPLY_W-1:0] SUPPLY_VOLTS_RST = 6'd11;
	localparam logic [DGAIN_W-1:0]  DUTY_GAIN_RST    = 14'd4239;

	localparam logic [SENSOR_COUNT-1:0] PATTERN_RST = SENSOR_COUNT'(8);

	localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
	localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_BACK = 2'd2;

	localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_ERR  = 11'b000_0000_0010,
		ST_MI   = 11'b000_0000_0100,
		ST_MP   = 11'b000_0000_1000,
		ST_MD   = 11'b000_0001_0000,
		ST_MS   = 11'b000_0010_0000,
		ST_MN   = 11'b000_0100_0000,
		ST_VOLT = 11'b000_1000_0000,
		ST_ML   = 11'b001_0000_0000,
		ST_MR   = 11'b010_0000_0000,
		ST_DONE = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_op_t;

	// weighted line position; sensors seeing the line (bit low) contribute
	function automatic logic signed [ERR_W-1:0] error_of(input logic [SENSOR_COUNT-1:0] pat);
		logic signed [ERR_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			if (!pat[i]) begin
				acc = acc + ERR_W'(i - SENSOR_COUNT / 2);
			end
		end
		return acc;
	endfunction

	// drop 8 fraction bits, round to nearest with ties away from zero
	function automatic logic signed [RND_W-1:0] round_q8(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		t = v + PROD_W'(127) + PROD_W'(!v[PROD_W-1]);
		return t[PROD_W-1:8];
	endfunction

endpackage

### rtl/lsps_mul.sv
// ----------------------------------------------------------------------------
// lsps_mul: shared signed multiplier
// One registered signed product per cycle; the sequencer picks the operands.
// ----------------------------------------------------------------------------
module lsps_mul (
	input  logic                                 clk,
	input  lsps_pkg::mul_op_t                    op,
	output logic signed [lsps_pkg::PROD_W-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= lsps_pkg::PROD_W'(op.a) * lsps_pkg::PROD_W'(op.b);
	end

endmodule

### rtl/line_sensor_pid_steering.sv
// ----------------------------------------------------------------------------
// line_sensor_pid_steering: PID line follower with PWM drive outputs
// Each input transfer runs ERR, MI, MP, MD, MS, MN, VOLT, ML, MR and DONE
// before out_valid, and no input is taken outside IDLE. The single shared
// multiplier is used six times per item under the sequencer. A stalled
// result holds the sequencer in its last state and delays the next input
// transfer. A new item is taken while the previous result still waits on the
// output. Reset (arst_n low) restores register defaults, stored pattern 8,
// integral and last error zero, and clears the output valid.
// ----------------------------------------------------------------------------
module line_sensor_pid_steering (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lsps_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lsps_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [lsps_pkg::SENSOR_COUNT-1:0]      sensor_bits,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [lsps_pkg::DUTY_W-1:0]            left_duty,
	output logic [lsps_pkg::DUTY_W-1:0]            right_duty,
	output logic [lsps_pkg::DIR_W-1:0]             left_direction,
	output logic [lsps_pkg::DIR_W-1:0]             right_direction,
	output logic                                   pattern_held
);

	localparam int N  = lsps_pkg::SENSOR_COUNT;
	localparam int AW = lsps_pkg::MUL_A_W;
	localparam int BW = lsps_pkg::MUL_B_W;
	localparam int PW = lsps_pkg::PROD_W;
	localparam int RW = lsps_pkg::RND_W;
	localparam int VW = lsps_pkg::VOLT_W;
	localparam int DW = lsps_pkg::DUTY_W;
	localparam int LW = lsps_pkg::LAST_ERR_W;
	localparam int ACC_MAX = 2 ** (lsps_pkg::ACC_W - 1) - 1;
	localparam int LE_MAX  = 2 ** (LW - 1) - 1;

	// configuration registers
	logic [lsps_pkg::PROP_W-1:0]   prop_gain_q;
	logic [lsps_pkg::INTEG_W-1:0]  integ_gain_q;
	logic [lsps_pkg::DERIV_W-1:0]  deriv_gain_q;
	logic [lsps_pkg::NORM_W-1:0]   norm_gain_q;
	logic [lsps_pkg::SUPPLY_W-1:0] supply_volts_q;
	logic [lsps_pkg::DGAIN_W-1:0]  duty_gain_q;

	lsps_pkg::state_t state_q;

	logic [N-1:0]                        last_good_q;
	logic [N-1:0]                        pat_q;
	logic                                held_q;
	logic signed [lsps_pkg::ERR_W-1:0]   e_q;
	logic signed [lsps_pkg::ACC_W-1:0]   acc_q;
	logic signed [LW-1:0]                last_err_q;
	logic signed [lsps_pkg::SUM_W-1:0]   sum_q;
	logic signed [VW-1:0]                volt_l_q;
	logic signed [VW-1:0]                volt_r_q;
	logic [DW-1:0]                       duty_l_q;

	logic                                out_valid_q;
	logic [DW-1:0]                       left_duty_q;
	logic [DW-1:0]                       right_duty_q;
	logic [lsps_pkg::DIR_W-1:0]          left_dir_q;
	logic [lsps_pkg::DIR_W-1:0]          right_dir_q;
	logic                                held_out_q;

	lsps_pkg::mul_op_t                   mul_op;
	logic signed [PW-1:0]                prod_q;

	logic                                in_xfer;
	logic                                out_xfer;
	logic                                raw_held;
	logic signed [AW-1:0]                e_ext;
	logic signed [AW-1:0]                acc_ext;
	logic signed [AW-1:0]                le_ext;
	logic signed [RW-1:0]                rnd;
	logic                                int_clear;
	logic signed [RW-1:0]                vq;
	logic signed [RW-1:0]                cand_l;
	logic signed [RW-1:0]                cand_r;
	logic signed [RW-1:0]                clamp_l;
	logic signed [RW-1:0]                clamp_r;
	logic signed [VW-1:0]                abs_l;
	logic signed [VW-1:0]                abs_r;
	logic [DW-1:0]                       duty_sat;
	logic signed [LW-1:0]                le_sat;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != lsps_pkg::ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	assign raw_held  = (sensor_bits == '0) || (sensor_bits == '1);

	assign e_ext   = AW'(e_q);
	assign acc_ext = AW'(acc_q);
	assign le_ext  = AW'(last_err_q);
	assign rnd     = lsps_pkg::round_q8(prod_q);

	// clear on zero error or when integral and last error disagree in sign
	assign int_clear = (e_q == '0) ||
		({acc_q[lsps_pkg::ACC_W-1], |acc_q} != {last_err_q[LW-1], |last_err_q});

	assign le_sat = (e_q > lsps_pkg::ERR_W'(LE_MAX)) ? LW'(LE_MAX) :
		(e_q < -lsps_pkg::ERR_W'(LE_MAX + 1)) ? LW'(-(LE_MAX + 1)) : e_q[LW-1:0];

	// steering voltages from the registered pid product, or a hard turn when an outer sensor pair sees the line
	always_comb begin
		vq     = RW'({supply_volts_q, 8'b0});
		cand_l = vq;
		cand_r = vq;
		if (rnd > 0) begin
			cand_r = vq - rnd;
		end else if (rnd < 0) begin
			cand_l = vq + rnd;
		end
		if (pat_q[1:0] == 2'b00) begin
			cand_l = -vq;
			cand_r = vq;
		end else if (pat_q[N-1:N-2] == 2'b00) begin
			cand_l = vq;
			cand_r = -vq;
		end
		clamp_l = (cand_l < -vq) ? -vq : ((cand_l > vq) ? vq : cand_l);
		clamp_r = (cand_r < -vq) ? -vq : ((cand_r > vq) ? vq : cand_r);
	end

	assign abs_l    = volt_l_q[VW-1] ? -volt_l_q : volt_l_q;
	assign abs_r    = volt_r_q[VW-1] ? -volt_r_q : volt_r_q;
	assign duty_sat = (|prod_q[PW-1:16+DW]) ? lsps_pkg::DUTY_MAX : prod_q[16+DW-1:16];

	// operand select for the shared multiplier
	always_comb begin
		mul_op = '0;
		case (state_q)
			lsps_pkg::ST_MI: begin
				mul_op.a = acc_ext + (e_ext <<< 8);
				mul_op.b = BW'(integ_gain_q);
			end
			lsps_pkg::ST_MP: begin
				mul_op.a = e_ext;
				mul_op.b = BW'(prop_gain_q);
			end
			lsps_pkg::ST_MD: begin
				mul_op.a = e_ext - le_ext;
				mul_op.b = BW'(deriv_gain_q);
			end
			lsps_pkg::ST_MN: begin
				mul_op.a = AW'(sum_q);
				mul_op.b = BW'(norm_gain_q);
			end
			lsps_pkg::ST_ML: begin
				mul_op.a = AW'(abs_l);
				mul_op.b = BW'(duty_gain_q);
			end
			// keep the right duty product while the result waits
			lsps_pkg::ST_MR, lsps_pkg::ST_DONE: begin
				mul_op.a = AW'(abs_r);
				mul_op.b = BW'(duty_gain_q);
			end
			default: begin
				mul_op = '0;
			end
		endcase
	end

	lsps_mul u_mul (
		.clk    (clk),
		.op     (mul_op),
		.prod_q (prod_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q    <= lsps_pkg::PROP_GAIN_RST;
			integ_gain_q   <= lsps_pkg::INTEG_GAIN_RST;
			deriv_gain_q   <= lsps_pkg::DERIV_GAIN_RST;
			norm_gain_q    <= lsps_pkg::NORM_GAIN_RST;
			supply_volts_q <= lsps_pkg::SUPPLY_VOLTS_RST;
			duty_gain_q    <= lsps_pkg::DUTY_GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lsps_pkg::REG_PROP_GAIN:    prop_gain_q    <= cfg_data[lsps_pkg::PROP_W-1:0];
				lsps_pkg::REG_INTEG_GAIN:   integ_gain_q   <= cfg_data[lsps_pkg::INTEG_W-1:0];
				lsps_pkg::REG_DERIV_GAIN:   deriv_gain_q   <= cfg_data[lsps_pkg::DERIV_W-1:0];
				lsps_pkg::REG_NORM_GAIN:    norm_gain_q    <= cfg_data[lsps_pkg::NORM_W-1:0];
				lsps_pkg::REG_SUPPLY_VOLTS: supply_volts_q <= cfg_data[lsps_pkg::SUPPLY_W-1:0];
				lsps_pkg::REG_DUTY_GAIN:    duty_gain_q    <= cfg_data[lsps_pkg::DGAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lsps_pkg::ST_IDLE;
			last_good_q <= lsps_pkg::PATTERN_RST;
			acc_q       <= '0;
			last_err_q  <= '0;
		end else begin
			case (state_q)
				lsps_pkg::ST_IDLE: begin
					if (in_xfer) begin
						if (!raw_held) begin
							last_good_q <= sensor_bits;
						end
						state_q <= lsps_pkg::ST_ERR;
					end
				end
				lsps_pkg::ST_ERR:  state_q <= lsps_pkg::ST_MI;
				lsps_pkg::ST_MI:   state_q <= lsps_pkg::ST_MP;
				lsps_pkg::ST_MP: begin
					if (int_clear) begin
						acc_q <= '0;
					end else if (rnd > RW'(ACC_MAX)) begin
						acc_q <= lsps_pkg::ACC_W'(ACC_MAX);
					end else if (rnd < -RW'(ACC_MAX + 1)) begin
						acc_q <= lsps_pkg::ACC_W'(-(ACC_MAX + 1));
					end else begin
						acc_q <= rnd[lsps_pkg::ACC_W-1:0];
					end
					state_q <= lsps_pkg::ST_MD;
				end
				lsps_pkg::ST_MD:   state_q <= lsps_pkg::ST_MS;
				lsps_pkg::ST_MS: begin
					last_err_q <= le_sat;
					state_q    <= lsps_pkg::ST_MN;
				end
				lsps_pkg::ST_MN:   state_q <= lsps_pkg::ST_VOLT;
				lsps_pkg::ST_VOLT: state_q <= lsps_pkg::ST_ML;
				lsps_pkg::ST_ML:   state_q <= lsps_pkg::ST_MR;
				lsps_pkg::ST_MR:   state_q <= lsps_pkg::ST_DONE;
				lsps_pkg::ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						state_q <= lsps_pkg::ST_IDLE;
					end
				end
				default: state_q <= lsps_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pat_q  <= raw_held ? last_good_q : sensor_bits;
			held_q <= raw_held;
		end
		if (state_q == lsps_pkg::ST_ERR) begin
			e_q <= lsps_pkg::error_of(pat_q);
		end
		if (state_q == lsps_pkg::ST_MD) begin
			sum_q <= prod_q[lsps_pkg::SUM_W-1:0];
		end
		if (state_q == lsps_pkg::ST_MS) begin
			sum_q <= sum_q + prod_q[lsps_pkg::SUM_W-1:0] + lsps_pkg::SUM_W'(acc_q);
		end
		if (state_q == lsps_pkg::ST_VOLT) begin
			volt_l_q <= clamp_l[VW-1:0];
			volt_r_q <= clamp_r[VW-1:0];
		end
		if (state_q == lsps_pkg::ST_MR) begin
			duty_l_q <= duty_sat;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == lsps_pkg::ST_DONE && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lsps_pkg::ST_DONE && (!out_valid_q || !out_stall)) begin
			left_duty_q  <= duty_l_q;
			right_duty_q <= duty_sat;
			left_dir_q   <= (volt_l_q > 0) ? lsps_pkg::DIR_FWD :
				((volt_l_q < 0) ? lsps_pkg::DIR_BACK : lsps_pkg::DIR_STOP);
			right_dir_q  <= (volt_r_q > 0) ? lsps_pkg::DIR_FWD :
				((volt_r_q < 0) ? lsps_pkg::DIR_BACK : lsps_pkg::DIR_STOP);
			held_out_q   <= held_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign left_duty       = left_duty_q;
	assign right_duty      = right_duty_q;
	assign left_direction  = left_dir_q;
	assign right_direction = right_dir_q;
	assign pattern_held    = held_out_q;

endmodule

### rtl/lsps_checker.sv
// ----------------------------------------------------------------------------
// lsps_checker: port-level checks for line_sensor_pid_steering
// Watches the input and output handshakes and the direction codes at the top-level ports.
// ----------------------------------------------------------------------------
module lsps_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_stall,
	input logic                                   out_valid,
	input logic                                   out_stall,
	input logic [lsps_pkg::DUTY_W-1:0]            left_duty,
	input logic [lsps_pkg::DUTY_W-1:0]            right_duty,
	input logic [lsps_pkg::DIR_W-1:0]             left_direction,
	input logic [lsps_pkg::DIR_W-1:0]             right_direction,
	input logic                                   pattern_held
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(left_duty) && $stable(right_duty) &&
		$stable(left_direction) && $stable(right_direction) && $stable(pattern_held))
		else $error("stalled result changed");

	// an accepted sample keeps the block busy on the next cycle
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// direction codes stay within stop, forward, backward
	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		(left_direction == lsps_pkg::DIR_STOP || left_direction == lsps_pkg::DIR_FWD ||
		left_direction == lsps_pkg::DIR_BACK) &&
		(right_direction == lsps_pkg::DIR_STOP || right_direction == lsps_pkg::DIR_FWD ||
		right_direction == lsps_pkg::DIR_BACK))
		else $error("invalid direction code");

endmodule

bind line_sensor_pid_steering lsps_checker u_lsps_checker (.*);
